// ===== src/nsr_pkg.sv =====
// Shared widths, constants and types for the Newton square-root block.
// Used by nsr_div and newton_square_root; no dependencies.
package nsr_pkg;

  localparam int INPUT_BITS = 16;
  localparam int FRAC_BITS  = 16;
  localparam int ROOT_BITS  = INPUT_BITS / 2 + 1 + FRAC_BITS;
  localparam int DIVD_BITS  = INPUT_BITS + 2 * FRAC_BITS;
  localparam int SQ_BITS    = 2 * ROOT_BITS;
  localparam int CNT_BITS   = $clog2(DIVD_BITS + 1);
  localparam int TOL_BITS   = 16;
  localparam int STEP_BITS  = 6;
  localparam int CFG_BITS   = 16;
  localparam int CFG_IDX_BITS = 1;

  // 2.0 in fixed point
  localparam logic [ROOT_BITS-1:0] SEED     = ROOT_BITS'(2) << FRAC_BITS;
  localparam logic [ROOT_BITS-1:0] ROOT_MAX = '1;

  localparam logic [TOL_BITS-1:0]  TOL_RESET  = TOL_BITS'(7);
  localparam logic [STEP_BITS-1:0] ITER_RESET = STEP_BITS'(32);

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_TOLERANCE = 1'b0,
    CFG_MAX_ITER  = 1'b1
  } cfg_index_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_CHECK,
    ST_DIVIDE
  } state_t;

endpackage

// ===== src/nsr_div.sv =====
// Restoring divider, one quotient bit per cycle: (x << 2*FRAC_BITS) / divisor, zero as 2.0.
// Depends on nsr_pkg.
module nsr_div (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [nsr_pkg::INPUT_BITS-1:0] x,
  input  logic [nsr_pkg::ROOT_BITS-1:0]  divisor,
  output logic                           done,
  output logic [nsr_pkg::DIVD_BITS-1:0]  quotient
);
  import nsr_pkg::*;

  logic                   busy;
  logic [CNT_BITS-1:0]    count;
  logic [ROOT_BITS-1:0]   rem;
  logic [ROOT_BITS-1:0]   dvsr;
  logic [DIVD_BITS-1:0]   shreg;   // dividend bits out the top, quotient bits in the bottom
  logic [ROOT_BITS:0]     shifted;
  logic [ROOT_BITS:0]     diff;
  logic                   ge;

  assign shifted  = {rem, shreg[DIVD_BITS-1]};
  assign diff     = shifted - {1'b0, dvsr};
  assign ge       = shifted >= {1'b0, dvsr};
  assign quotient = shreg;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && count == CNT_BITS'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      shreg <= DIVD_BITS'(x) << (2 * FRAC_BITS);
      rem   <= '0;
      count <= CNT_BITS'(DIVD_BITS);
      dvsr  <= (divisor == '0) ? SEED : divisor;
    end else if (busy) begin
      rem   <= ge ? diff[ROOT_BITS-1:0] : shifted[ROOT_BITS-1:0];
      shreg <= {shreg[DIVD_BITS-2:0], ge};
      count <= count - CNT_BITS'(1);
    end
  end

  a_done_pulse: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("divider done held longer than one cycle");
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("divider done while still busy");
  a_rem_bound: assert property (@(posedge clk) disable iff (rst) busy |-> rem < dvsr)
    else $error("partial remainder not below divisor");

endmodule

// ===== src/newton_square_root.sv =====
// Top level: Newton/Heron square root sequencer around a shared divider and squarer.
// Depends on nsr_pkg and nsr_div.
//
// Channel   Direction  Handshake             Payload
// -------   ---------  --------------------  -------------------------------------
// in        into       in_valid / in_stall   radicand[15:0]
// out       out of     out_valid / out_stall root[24:0], converged, steps_taken[5:0]
// cfg       into       cfg_write             cfg_index (0 tolerance, 1 max_iterations),
//                                            cfg_data[15:0]
//
// Per input: each Newton step passes the square state, the tolerance check state and
//   the bit-serial divider (48 quotient bits); one extra divide step after the answer
//   seeds the next input.
// Reset (rst, synchronous): estimate returns to 2.0, tolerance 7, max_iterations 32.
// in_stall is high for the whole time an input is in work; the answer sits in an
//   output register, so a stalled result only holds the sequencer at the check that
//   would produce the following answer.
module newton_square_root (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [nsr_pkg::INPUT_BITS-1:0]    radicand,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [nsr_pkg::ROOT_BITS-1:0]     root,
  output logic                              converged,
  output logic [nsr_pkg::STEP_BITS-1:0]     steps_taken,
  input  logic                              cfg_write,
  input  logic [nsr_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [nsr_pkg::CFG_BITS-1:0]      cfg_data
);
  import nsr_pkg::*;

  state_t                 state, state_next;
  logic [INPUT_BITS-1:0]  x_reg, x_reg_next;
  logic [ROOT_BITS-1:0]   y, y_next;
  logic [STEP_BITS-1:0]   steps, steps_next;
  logic                   post, post_next;
  logic [ROOT_BITS-1:0]   estimate, estimate_next;
  logic [TOL_BITS-1:0]    tolerance;
  logic [STEP_BITS-1:0]   max_iter;
  logic [SQ_BITS-1:0]     sq;

  logic                   out_valid_next;
  logic                   load_out;

  logic                   div_start;
  logic                   div_done;
  logic [DIVD_BITS-1:0]   div_quot;

  // tolerance test: |x*2^(2F) - y^2| < tol*2^F
  logic [SQ_BITS-1:0]     target;
  logic [SQ_BITS-1:0]     err;
  logic                   tol_ok;
  logic                   limit_hit;
  logic                   out_free;

  // y' = (q + y) / 2, saturated, zero reseeded
  logic [DIVD_BITS:0]     sum;
  logic [DIVD_BITS-1:0]   half;
  logic [ROOT_BITS-1:0]   step_y;

  nsr_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .x        (x_reg),
    .divisor  (y),
    .done     (div_done),
    .quotient (div_quot)
  );

  assign target    = SQ_BITS'(x_reg) << (2 * FRAC_BITS);
  assign err       = (target >= sq) ? (target - sq) : (sq - target);
  assign tol_ok    = err < (SQ_BITS'(tolerance) << FRAC_BITS);
  assign limit_hit = steps >= max_iter;
  assign out_free  = !out_valid || !out_stall;

  assign sum  = (DIVD_BITS + 1)'(div_quot) + (DIVD_BITS + 1)'(y);
  assign half = sum[DIVD_BITS:1];

  always_comb begin
    if (half > DIVD_BITS'(ROOT_MAX)) begin
      step_y = ROOT_MAX;
    end else if (half == '0) begin
      step_y = SEED;
    end else begin
      step_y = half[ROOT_BITS-1:0];
    end
  end

  assign in_stall = (state != ST_IDLE);

  // sequencer
  always_comb begin
    state_next     = state;
    x_reg_next     = x_reg;
    y_next         = y;
    steps_next     = steps;
    post_next      = post;
    estimate_next  = estimate;
    load_out       = 1'b0;
    div_start      = 1'b0;
    out_valid_next = out_valid && out_stall;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          x_reg_next = radicand;
          y_next     = estimate;
          steps_next = '0;
          state_next = ST_SQUARE;
        end
      end
      ST_SQUARE: begin
        state_next = ST_CHECK;
      end
      ST_CHECK: begin
        if (tol_ok || limit_hit) begin
          // answer now, then one more step toward x seeds the next input
          if (out_free) begin
            load_out       = 1'b1;
            out_valid_next = 1'b1;
            post_next      = 1'b1;
            div_start      = 1'b1;
            state_next     = ST_DIVIDE;
          end
        end else begin
          post_next  = 1'b0;
          div_start  = 1'b1;
          state_next = ST_DIVIDE;
        end
      end
      ST_DIVIDE: begin
        if (div_done) begin
          if (post) begin
            estimate_next = step_y;
            state_next    = ST_IDLE;
          end else begin
            y_next     = step_y;
            steps_next = steps + STEP_BITS'(1);
            state_next = ST_SQUARE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
      estimate  <= SEED;
      post      <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
      estimate  <= estimate_next;
      post      <= post_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tolerance <= TOL_RESET;
      max_iter  <= ITER_RESET;
    end else if (cfg_write) begin
      case (cfg_index_t'(cfg_index))
        CFG_TOLERANCE: tolerance <= cfg_data[TOL_BITS-1:0];
        CFG_MAX_ITER:  max_iter  <= cfg_data[STEP_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    x_reg <= x_reg_next;
    y     <= y_next;
    steps <= steps_next;
    sq    <= SQ_BITS'(y) * SQ_BITS'(y);
    if (load_out) begin
      root        <= y;
      converged   <= tol_ok;
      steps_taken <= steps;
    end
  end

  a_out_from_check: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == ST_CHECK))
    else $error("result raised outside the tolerance check");
  a_div_in_divide: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == ST_DIVIDE)
    else $error("divider finished while sequencer not waiting");
  a_estimate_nonzero: assert property (@(posedge clk) disable iff (rst)
    estimate != '0)
    else $error("stored estimate is zero");
  a_fail_at_limit: assert property (@(posedge clk) disable iff (rst)
    out_valid && !converged |-> steps_taken == max_iter)
    else $error("unconverged result before iteration limit");

endmodule
